// ===== sv/xor_float_stream_compressor_assert.svh =====
// assertion helpers for the compressor modules, used by the packer (xfc_back)
`ifndef XOR_FLOAT_STREAM_COMPRESSOR_ASSERT_SVH
`define XOR_FLOAT_STREAM_COMPRESSOR_ASSERT_SVH

// condition holds at every edge out of reset
`define XFC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define XFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/xfc_pkg.sv =====
package xfc_pkg;

    localparam int VALUE_BITS  = 32;
    // longest code: two flag bits, 5 bit lead, 6 bit length, 32 meaningful bits, padded
    localparam int CODE_BITS   = 48;
    localparam int LEN_BITS    = 6;
    localparam int BUF_BITS    = CODE_BITS + 8;
    localparam int FILL_BITS   = 6;
    // up to 7 pending bits plus a 45 bit code
    localparam logic [FILL_BITS-1:0] FILL_MAX = 6'd52;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_APPEND,
        KIND_FINISH,
        KIND_RESTART
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [CODE_BITS-1:0]   code;   // left aligned, zeros after len bits
        logic [LEN_BITS-1:0]    len;
        logic [VALUE_BITS-1:0]  count;
    } t_qent;

endpackage

// ===== sv/xfc_front.sv =====
module xfc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_op,
    input  logic [xfc_pkg::VALUE_BITS-1:0] i_sample,
    output logic                           o_push,
    input  logic                           i_full,
    output xfc_pkg::t_qent                 o_ent
);
    import xfc_pkg::*;

    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [5:0] NO_WINDOW  = 6'd63;

    typedef enum logic [1:0] {
        FORM_RAW,
        FORM_ZERO,
        FORM_INWIN,
        FORM_NEWWIN
    } t_form;

    function automatic logic [4:0] clz32(input logic [31:0] x);
        logic [31:0] v;
        logic [4:0]  n;
        v = x;
        n = '0;
        if (v[31:16] == '0) begin
            n[4] = 1'b1;
            v    = v << 16;
        end
        if (v[31:24] == '0) begin
            n[3] = 1'b1;
            v    = v << 8;
        end
        if (v[31:28] == '0) begin
            n[2] = 1'b1;
            v    = v << 4;
        end
        if (v[31:30] == '0) begin
            n[1] = 1'b1;
            v    = v << 2;
        end
        if (!v[31]) begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

    function automatic logic [31:0] rev32(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = x[31-i];
        end
        return r;
    endfunction

    // series state
    logic [VALUE_BITS-1:0] r_prev;
    logic [5:0]            r_wl;
    logic [4:0]            r_wt;
    logic                  r_first;
    logic [VALUE_BITS-1:0] r_count;

    // classified item waiting for the queue
    logic                  r_a_valid;
    t_kind                 r_a_kind;
    t_form                 r_a_form;
    logic [VALUE_BITS-1:0] r_a_x;
    logic [4:0]            r_a_lead;
    logic [5:0]            r_a_mlen;
    logic [VALUE_BITS-1:0] r_a_count;

    logic                  accept;
    logic [VALUE_BITS-1:0] x;
    logic [4:0]            lead;
    logic [4:0]            trail;
    logic                  fits;
    t_form                 form;
    logic [4:0]            lead_used;
    logic [5:0]            mlen;
    logic [VALUE_BITS-1:0] count_inc;
    logic [VALUE_BITS-1:0] p;

    assign o_ready   = !r_a_valid || !i_full;
    assign accept    = i_valid && o_ready;
    assign o_push    = r_a_valid && !i_full;

    assign x         = i_sample ^ r_prev;
    assign lead      = clz32(x);
    assign trail     = clz32(rev32(x));
    assign fits      = ({1'b0, lead} >= r_wl) && (trail >= r_wt);
    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;

    always_comb begin
        if (!r_first) begin
            form      = FORM_RAW;
            lead_used = '0;
            mlen      = 6'd32;
        end else if (x == '0) begin
            form      = FORM_ZERO;
            lead_used = '0;
            mlen      = '0;
        end else if (fits) begin
            form      = FORM_INWIN;
            lead_used = r_wl[4:0];
            mlen      = 6'd32 - r_wl - {1'b0, r_wt};
        end else begin
            form      = FORM_NEWWIN;
            lead_used = lead;
            mlen      = 6'd32 - {1'b0, lead} - {1'b0, trail};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_prev    <= '0;
            r_wl      <= NO_WINDOW;
            r_wt      <= '0;
            r_first   <= 1'b0;
            r_count   <= '0;
        end else begin
            // the unused code is taken and dropped
            if (accept && (i_op != OP_UNUSED)) begin
                r_a_valid <= 1'b1;
            end else if (o_push) begin
                r_a_valid <= 1'b0;
            end
            if (accept) begin
                unique case (i_op) inside
                    OP_APPEND: begin
                        r_prev    <= i_sample;
                        r_first   <= 1'b1;
                        r_count   <= count_inc;
                        if (form == FORM_NEWWIN) begin
                            r_wl <= {1'b0, lead};
                            r_wt <= trail;
                        end
                    end
                    OP_FINISH, OP_RESTART: begin
                        r_prev    <= '0;
                        r_wl      <= NO_WINDOW;
                        r_wt      <= '0;
                        r_first   <= 1'b0;
                        r_count   <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_x     <= x;
            r_a_form  <= form;
            r_a_lead  <= lead_used;
            r_a_mlen  <= mlen;
            r_a_count <= (i_op == OP_APPEND) ? count_inc : r_count;
            unique case (i_op)
                OP_APPEND: r_a_kind <= KIND_APPEND;
                OP_FINISH: r_a_kind <= KIND_FINISH;
                default:   r_a_kind <= KIND_RESTART;
            endcase
        end
    end

    // meaningful bits moved to the top, window trailing zeros follow
    assign p = r_a_x << r_a_lead;

    always_comb begin
        o_ent.kind  = r_a_kind;
        o_ent.count = r_a_count;
        unique case (r_a_form)
            FORM_RAW: begin
                o_ent.code = {p, 16'b0};
                o_ent.len  = 6'd32;
            end
            FORM_ZERO: begin
                o_ent.code = '0;
                o_ent.len  = 6'd1;
            end
            FORM_INWIN: begin
                o_ent.code = {2'b10, p, 14'b0};
                o_ent.len  = 6'd2 + r_a_mlen;
            end
            default: begin
                o_ent.code = {2'b11, r_a_lead, r_a_mlen, p, 3'b0};
                o_ent.len  = 6'd13 + r_a_mlen;
            end
        endcase
    end

endmodule

// ===== sv/xfc_queue.sv =====
module xfc_queue #(
    parameter int DEPTH = xfc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xfc_pkg::t_qent i_ent,
    output logic           o_full,
    output logic           o_valid,
    output xfc_pkg::t_qent o_ent,
    input  logic           i_pop
);
    import xfc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qent           r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_fill;

    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_ent   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

endmodule

// ===== sv/xfc_back.sv =====
`include "xor_float_stream_compressor_assert.svh"

module xfc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  xfc_pkg::t_qent                 i_q_ent,
    output logic                           o_pop,
    output logic                           o_m_valid,
    input  logic                           i_m_ready,
    output logic [7:0]                     o_m_byte,
    output logic                           o_m_last,
    output logic [xfc_pkg::VALUE_BITS-1:0] o_m_count
);
    import xfc_pkg::*;

    // pending bits, left aligned, zero below the fill level
    logic [BUF_BITS-1:0]   r_buf;
    logic [FILL_BITS-1:0]  r_bits;
    logic [VALUE_BITS-1:0] r_cnt;
    logic                  r_m_valid;
    logic [7:0]            r_m_byte;
    logic                  r_m_last;
    logic [VALUE_BITS-1:0] r_m_count;

    logic [BUF_BITS-1:0]   n_buf;
    logic [FILL_BITS-1:0]  n_bits;
    logic [VALUE_BITS-1:0] n_cnt;
    logic                  out_free;
    logic                  emit;

    assign out_free = !r_m_valid || i_m_ready;
    assign emit     = (r_bits >= 6'd8) && out_free;
    assign o_pop    = (r_bits < 6'd8) && i_q_valid;

    always_comb begin
        n_buf  = r_buf;
        n_bits = r_bits;
        n_cnt  = r_cnt;
        if (emit) begin
            n_buf  = r_buf << 8;
            n_bits = r_bits - 6'd8;
        end else if (o_pop) begin
            case (i_q_ent.kind)
                KIND_APPEND: begin
                    n_buf  = r_buf | ({i_q_ent.code, 8'b0} >> r_bits[2:0]);
                    n_bits = r_bits + i_q_ent.len;
                    n_cnt  = i_q_ent.count;
                end
                KIND_FINISH: begin
                    // a partial word goes out zero padded
                    n_bits = (r_bits != '0) ? 6'd8 : 6'd0;
                    n_cnt  = i_q_ent.count;
                end
                default: begin
                    n_buf  = '0;
                    n_bits = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf     <= '0;
            r_bits    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_buf  <= n_buf;
            r_bits <= n_bits;
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (emit) begin
            r_m_byte  <= r_buf[BUF_BITS-1 -: 8];
            r_m_last  <= (r_bits < 6'd16);
            r_m_count <= r_cnt;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_byte  = r_m_byte;
    assign o_m_last  = r_m_last;
    assign o_m_count = r_m_count;

    `XFC_ASSERT_ALWAYS(a_fill_bound, r_bits <= FILL_MAX, "packer fill above longest code")
    `XFC_ASSERT_ALWAYS(a_buf_clean, (r_buf << r_bits) == '0, "stale bits below fill level")
    `XFC_ASSERT_NEXT(a_last_drains, emit && (r_bits < 6'd16), r_bits < 6'd8, "full word after last")

endmodule

// ===== sv/xor_float_stream_compressor.sv =====
// channel  | dir | tdata                               | tuser          | tlast
// s_axis   | in  | [31:0] sample_bits                  | [1:0] operation | -
// m_axis   | out | [7:0] out_byte, [39:8] value_count  | -              | last_byte
//
// the front classifies and encodes one item per cycle into a Q_DEPTH entry queue,
// and stalls while its held item waits on a full queue; the packer loads an item while
// fewer than 8 bits are pending, then sends out whole bytes, waiting on the output, up to 6
// per item; reset is synchronous, active low, and clears the control state (not the data registers or queue storage)
// m_axis_tready low holds the output word, the packer waits, the queue fills,
// then s_axis_tready drops
module xor_float_stream_compressor #(
    parameter int Q_DEPTH = xfc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] value_count
    output logic        m_axis_tlast    // last_byte
);
    import xfc_pkg::*;

    logic                  push;
    logic                  full;
    t_qent                 ent_in;
    logic                  q_valid;
    t_qent                 ent_out;
    logic                  pop;
    logic [7:0]            m_byte;
    logic [VALUE_BITS-1:0] m_count;

    xfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_op     (s_axis_tuser),
        .i_sample (s_axis_tdata),
        .o_push   (push),
        .i_full   (full),
        .o_ent    (ent_in)
    );

    xfc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (ent_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_ent   (ent_out),
        .i_pop   (pop)
    );

    xfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ent   (ent_out),
        .o_pop     (pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_byte  (m_byte),
        .o_m_last  (m_axis_tlast),
        .o_m_count (m_count)
    );

    assign m_axis_tdata = {m_count, m_byte};

endmodule

// ===== tb/sv/xfc_code_checker.sv =====
module xfc_code_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] sample_bits
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] i_m_axis_tdata,   // [7:0] out_byte, [39:8] value_count
    input  logic        i_m_axis_tlast,   // last_byte
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import xfc_pkg::*;

    localparam int LEAD_FIELD_W = 5;
    localparam int BYTE_W       = 8;

    typedef struct packed {
        logic [7:0]            data;
        logic                  last;
        logic [VALUE_BITS-1:0] count;
    } t_word;

    // series state of the encoder
    logic [VALUE_BITS-1:0] prev_sample;
    logic [5:0]            win_lead;
    logic [5:0]            win_trail;
    logic [7:0]            acc_byte;
    int                    free_bits;
    logic                  started;
    logic [VALUE_BITS-1:0] sample_count;

    logic [7:0] item_bytes[$];
    t_word      expected_words[$];

    int fail_total = 0;
    int pending    = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending;

    function automatic void clear_series();
        prev_sample  = '0;
        win_lead     = 6'd63;   // no window yet
        win_trail    = '0;
        acc_byte     = '0;
        free_bits    = BYTE_W;
        started      = 1'b0;
        sample_count = '0;
    endfunction

    // msb first into the pending byte, full bytes go to the item list
    function automatic void put_code_bits(input logic [63:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            acc_byte[free_bits-1] = bits[i];
            free_bits--;
            if (free_bits == 0) begin
                item_bytes.push_back(acc_byte);
                acc_byte  = '0;
                free_bits = BYTE_W;
            end
        end
    endfunction

    function automatic int lead_zeros(input logic [VALUE_BITS-1:0] x);
        int c;
        c = 0;
        while (c < VALUE_BITS && !x[VALUE_BITS-1-c]) c++;
        return c;
    endfunction

    function automatic int trail_zeros(input logic [VALUE_BITS-1:0] x);
        int c;
        c = 0;
        while (c < VALUE_BITS && !x[c]) c++;
        return c;
    endfunction

    function automatic void encode_sample(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] x;
        int lz;
        int tz;
        int mlen;
        x = v ^ prev_sample;
        if (!started) begin
            put_code_bits(64'(v), VALUE_BITS);
            started = 1'b1;
        end else if (x == '0) begin
            put_code_bits(64'(0), 1);
        end else begin
            lz = lead_zeros(x);
            tz = trail_zeros(x);
            put_code_bits(64'(1), 1);
            if (lz >= int'(win_lead) && tz >= int'(win_trail)) begin
                mlen = VALUE_BITS - int'(win_lead) - int'(win_trail);
                put_code_bits(64'(0), 1);
                put_code_bits(64'(x >> win_trail), mlen);
            end else begin
                mlen = VALUE_BITS - lz - tz;
                put_code_bits(64'(1), 1);
                put_code_bits(64'(lz), LEAD_FIELD_W);
                put_code_bits(64'(mlen), LEN_BITS);
                put_code_bits(64'(x >> tz), mlen);
                win_lead  = lz[5:0];
                win_trail = tz[5:0];
            end
        end
        prev_sample = v;
        if (sample_count != '1) sample_count++;
    endfunction

    function automatic void predict_item(input logic [1:0] op, input logic [31:0] bits);
        logic [VALUE_BITS-1:0] cnt;
        t_word w;
        cnt = '0;
        item_bytes.delete();
        case (op)
            KIND_APPEND: begin
                encode_sample(bits);
                cnt = sample_count;
            end
            KIND_FINISH: begin
                cnt = sample_count;
                if (free_bits != BYTE_W) item_bytes.push_back(acc_byte);
                clear_series();
            end
            KIND_RESTART: begin
                clear_series();
            end
            default: ;  // unused code, ignored by the block
        endcase
        foreach (item_bytes[i]) begin
            w.data  = item_bytes[i];
            w.last  = (i == item_bytes.size() - 1);
            w.count = cnt;
            expected_words.push_back(w);
        end
    endfunction

    function automatic void check_word();
        t_word exp_w;
        logic [7:0] got_byte;
        logic [VALUE_BITS-1:0] got_count;
        got_byte  = i_m_axis_tdata[7:0];
        got_count = i_m_axis_tdata[39:8];
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word: byte %02h last %0b count %0d",
                     $time, got_byte, i_m_axis_tlast, got_count);
            fail_total++;
        end else begin
            exp_w = expected_words.pop_front();
            if (exp_w.data !== got_byte) begin
                $display("%0t: out_byte expected %02h actual %02h",
                         $time, exp_w.data, got_byte);
                fail_total++;
            end
            if (exp_w.last !== i_m_axis_tlast) begin
                $display("%0t: last_byte expected %0b actual %0b",
                         $time, exp_w.last, i_m_axis_tlast);
                fail_total++;
            end
            if (exp_w.count !== got_count) begin
                $display("%0t: value_count expected %0d actual %0d",
                         $time, exp_w.count, got_count);
                fail_total++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_series();
            expected_words.delete();
        end else begin
            // words of a new item cannot leave in the cycle it is taken
            if (i_m_axis_tvalid && i_m_axis_tready) check_word();
            if (i_s_axis_tvalid && i_s_axis_tready) predict_item(i_s_axis_tuser, i_s_axis_tdata);
        end
        pending = expected_words.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import xfc_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         ITEM_COUNT = 230;
    localparam int         HOLD_LEN   = 120;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_DENSE} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] sample_bits
    logic [1:0]  s_axis_tuser;    // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [7:0] out_byte, [39:8] value_count
    logic        m_axis_tlast;    // last_byte

    int fail_count;
    int pending_words;
    int burst_left = 0;
    int items_sent = 0;

    always #5 i_clk = ~i_clk;

    xor_float_stream_compressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    xfc_code_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words)
    );

    // offer one word, with a random gap at the start of each burst
    task automatic send_word(input logic [1:0] op, input logic [31:0] bits);
        int gap;
        if (burst_left == 0) begin
            gap = (($urandom & 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        s_axis_tuser  <= op;
        burst_left--;
        if (op != OP_UNUSED) items_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // one series: mostly values close to the previous one within a bit band
    task automatic run_series();
        int len;
        int lo;
        int wid;
        int pick;
        logic [31:0] val;
        logic [31:0] band;
        len  = $urandom_range(1, 16);
        lo   = $urandom_range(0, 31);
        wid  = $urandom_range(1, 6);
        band = ((32'h1 << wid) - 1) << lo;
        val  = $urandom;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            if (i > 0) begin
                if (pick <= 1)      val = val;
                else if (pick <= 6) val = val ^ (band & $urandom);
                else if (pick == 7) val = val ^ ((pick & 1) ? 32'h8000_0000 : 32'h1);
                else if (pick == 8) val = $urandom;
                else                val = val ^ (($urandom & 32'hf) << $urandom_range(0, 28));
            end
            send_word(KIND_APPEND, val);
            if ($urandom_range(0, 24) == 0) send_word(OP_UNUSED, $urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick <= 6)      send_word(KIND_FINISH, $urandom);
        else if (pick <= 8) send_word(KIND_RESTART, $urandom);
        // otherwise the next series runs on without a boundary
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_APPEND;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // raw first value, repeats, full width window then its reuse
        send_word(KIND_APPEND, 32'h0000_0000);
        send_word(KIND_APPEND, 32'h0000_0000);
        send_word(KIND_APPEND, 32'hffff_ffff);
        send_word(KIND_APPEND, 32'hffff_ffff);
        send_word(KIND_APPEND, 32'h0000_0000);
        send_word(KIND_FINISH, 32'hffff_ffff);
        // finish with nothing pending
        send_word(KIND_FINISH, 32'h0000_0000);
        // sign bit only, then a window at the low end
        send_word(KIND_APPEND, 32'h3f80_0000);
        send_word(KIND_APPEND, 32'hbf80_0000);
        send_word(KIND_APPEND, 32'h3f80_0000);
        send_word(KIND_APPEND, 32'h3f80_0001);
        send_word(KIND_APPEND, 32'h3f80_0000);
        send_word(OP_UNUSED,   32'hffff_ffff);
        send_word(KIND_APPEND, 32'h7fc0_0000);
        send_word(KIND_APPEND, 32'h0000_0001);
        send_word(KIND_RESTART, 32'h5555_aaaa);
        send_word(KIND_APPEND, 32'h1234_5678);
        send_word(KIND_APPEND, 32'h1234_5679);
        send_word(KIND_FINISH, 32'haaaa_5555);
        // a lone raw value ends byte aligned
        send_word(KIND_APPEND, 32'h4049_0fdb);
        send_word(KIND_FINISH, 32'h0000_0000);
        send_word(OP_UNUSED,   32'h0000_0000);
        send_word(KIND_APPEND, 32'h8000_0000);
        send_word(KIND_APPEND, 32'h7fff_ffff);
        send_word(KIND_FINISH, 32'h0000_0000);

        while (items_sent < ITEM_COUNT) run_series();
        send_word(KIND_FINISH, $urandom);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_words != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("xor_float_stream_compressor: match");
        end else begin
            $display("xor_float_stream_compressor: mismatch");
        end
        $finish;
    end

    initial begin : receiver
        int run_len;
        int cyc;
        int next_hold;
        t_rx_mode mode;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        cyc       = 0;
        next_hold = 150;
        forever begin
            // long hold-off so the queue fills and the input stalls
            if (cyc >= next_hold) begin
                repeat (HOLD_LEN) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
                cyc       += HOLD_LEN;
                next_hold += 800;
            end
            mode    = t_rx_mode'($urandom_range(0, 3));
            run_len = $urandom_range(5, 40);
            repeat (run_len) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                cyc++;
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("xor_float_stream_compressor: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/xfc_pkg.sv
sv/xfc_front.sv
sv/xfc_queue.sv
sv/xfc_back.sv
sv/xor_float_stream_compressor.sv
tb/sv/xfc_code_checker.sv
tb/sv/tb.sv
